// File: hw/rtl/cie_pkg.sv
`default_nettype none

package cie_pkg;

    localparam int MAX_BYTES = 9;
    localparam int LEN_W     = 4;
    localparam int BUF_W     = MAX_BYTES * 8;

    // encoded bytes left-aligned: first byte in bits [BUF_W-1 -: 8]
    typedef struct packed {
        logic [BUF_W-1:0] bytes;
        logic [LEN_W-1:0] len;
    } cie_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/cie_front.sv
`default_nettype none

module cie_front
    import cie_pkg::*;
(
    input  wire logic [63:0] value,
    output cie_entry_t       entry
);

    logic [31:0] lo;
    logic [31:0] hi;
    logic        fits32;
    logic        i1, i2, i3, i4;
    logic        h1, h2, h3, h4;

    assign lo = value[31:0];
    assign hi = value[63:32];

    // a slice whose bits all match means the value fits that many signed bits
    assign fits32 = (&value[63:31]) | ~(|value[63:31]);
    assign i1 = (&lo[31:6])  | ~(|lo[31:6]);
    assign i2 = (&lo[31:13]) | ~(|lo[31:13]);
    assign i3 = (&lo[31:20]) | ~(|lo[31:20]);
    assign i4 = (&lo[31:27]) | ~(|lo[31:27]);
    assign h1 = (&hi[31:2])  | ~(|hi[31:2]);
    assign h2 = (&hi[31:9])  | ~(|hi[31:9]);
    assign h3 = (&hi[31:16]) | ~(|hi[31:16]);
    assign h4 = (&hi[31:23]) | ~(|hi[31:23]);

    always_comb
    begin
        entry.bytes = '0;
        entry.len   = LEN_W'(1);
        if (fits32)
        begin
            if (i1)
            begin
                entry.bytes = {1'b0, lo[6:0], 64'h0};
                entry.len   = LEN_W'(1);
            end
            else if (i2)
            begin
                entry.bytes = {2'b10, lo[13:0], 56'h0};
                entry.len   = LEN_W'(2);
            end
            else if (i3)
            begin
                entry.bytes = {3'b110, lo[20:0], 48'h0};
                entry.len   = LEN_W'(3);
            end
            else if (i4)
            begin
                entry.bytes = {4'b1110, lo[27:0], 40'h0};
                entry.len   = LEN_W'(4);
            end
            else
            begin
                entry.bytes = {5'b11110, {3{lo[31]}}, lo, 32'h0};
                entry.len   = LEN_W'(5);
            end
        end
        else
        begin
            if (h1)
            begin
                entry.bytes = {5'b11110, hi[2:0], lo, 32'h0};
                entry.len   = LEN_W'(5);
            end
            else if (h2)
            begin
                entry.bytes = {6'b111110, hi[9:0], lo, 24'h0};
                entry.len   = LEN_W'(6);
            end
            else if (h3)
            begin
                entry.bytes = {7'b1111110, hi[16:0], lo, 16'h0};
                entry.len   = LEN_W'(7);
            end
            else if (h4)
            begin
                entry.bytes = {8'hFE, hi[23:0], lo, 8'h0};
                entry.len   = LEN_W'(8);
            end
            else
            begin
                entry.bytes = {8'hFF, hi, lo};
                entry.len   = LEN_W'(9);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cie_queue.sv
`default_nettype none

module cie_queue
    import cie_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cie_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output cie_entry_t      pop_data,
    output logic            not_empty
);

    cie_entry_t  mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cie_back.sv
`default_nettype none

module cie_back
    import cie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cie_entry_t  q_data,
    input  wire logic        q_valid,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic [BUF_W-1:0] sh_reg;
    logic [BUF_W-1:0] sh_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic             active_reg;
    logic             active_next;
    logic             ov_reg;
    logic             ov_next;
    logic [7:0]       obyte_reg;
    logic [7:0]       obyte_next;
    logic             olast_reg;
    logic             olast_next;
    logic             out_free;
    logic             final_byte;

    assign out_free   = !ov_reg || m_tready;
    assign final_byte = (rem_reg == LEN_W'(1));
    assign q_pop      = q_valid && (!active_reg || (out_free && final_byte));

    always_comb
    begin
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        active_next = active_reg;
        ov_next     = ov_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (out_free)
        begin
            ov_next    = active_reg;
            obyte_next = sh_reg[BUF_W-1 -: 8];
            olast_next = final_byte;
        end
        if (q_pop)
        begin
            sh_next     = q_data.bytes;
            rem_next    = q_data.len;
            active_next = 1'b1;
        end
        else if (active_reg && out_free)
        begin
            sh_next     = {sh_reg[BUF_W-9:0], 8'h00};
            rem_next    = rem_reg - LEN_W'(1);
            active_next = !final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

// File: hw/rtl/compact_integer_encoder_core.sv
// Compact signed integer encoder.
// Slave channel (s_*): one transaction carries a signed 64-bit value.
// Master channel (m_*): one transaction per encoded byte, most significant
// first; m_tlast marks the final byte of a value's 1..9 byte encoding.
// The front classifies the value and builds the whole encoding in the
// accepting cycle; a two-entry queue holds it until the back serializer
// takes it into its shift register; each byte then passes through the
// output byte register. Throughput: one byte per cycle on the master side
// while m_tready is high; successive values stream without gaps. The
// output byte register is the rate limit.
// When m_tready is low, the output register holds, the serializer waits,
// and the queue keeps accepting until both entries are full, then s_tready
// drops. Reset empties the queue and the serializer and clears m_tvalid.
`default_nettype none

module compact_integer_encoder_core
    import cie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    cie_entry_t front_entry;
    cie_entry_t q_data;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    cie_front u_front (
        .value (s_tdata),
        .entry (front_entry)
    );

    cie_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    cie_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    import cie_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    enc_byte_t expected_bytes[$];
    int        idle_pct;
    int        stall_pct;
    int        err_count;
    int        values_sent;
    int        bytes_checked;
    int        len_count[1:MAX_BYTES];

    compact_integer_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Builds the byte sequence for one value, right-aligned in code, and
    // queues it first byte first.
    function automatic void predict_encoding(input logic signed [63:0] v);
        logic [71:0]        code;
        int                 n;
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic signed [31:0] h;
        lo = v[31:0];
        hi = v[63:32];
        h  = hi;
        if (v == $signed({{32{lo[31]}}, lo}))
        begin
            if (v >= 0)
            begin
                if (v < 64)             begin n = 1; code = 72'(lo[7:0]); end
                else if (v < 8192)      begin n = 2; code = 72'(lo[15:0] | 16'h8000); end
                else if (v < 1048576)   begin n = 3; code = 72'(lo[23:0] | 24'hC00000); end
                else if (v < 134217728) begin n = 4; code = 72'(lo | 32'hE000_0000); end
                else                    begin n = 5; code = 72'({8'hF0, lo}); end
            end
            else
            begin
                if (v >= -64)             begin n = 1; code = 72'(lo[7:0] & 8'h7F); end
                else if (v >= -8192)      begin n = 2; code = 72'(lo[15:0] & 16'hBFFF); end
                else if (v >= -1048576)   begin n = 3; code = 72'(lo[23:0] & 24'hDFFFFF); end
                else if (v >= -134217728) begin n = 4; code = 72'(lo & 32'hEFFF_FFFF); end
                else                      begin n = 5; code = 72'({8'hF7, lo}); end
            end
        end
        else
        begin
            if (h >= 0)
            begin
                if (h < 4)            begin n = 1; code = 72'(hi[7:0] | 8'hF0); end
                else if (h < 512)     begin n = 2; code = 72'(hi[15:0] | 16'hF800); end
                else if (h < 65536)   begin n = 3; code = 72'({8'hFC, hi[15:0]}); end
                else if (h < 8388608) begin n = 4; code = 72'(hi | 32'hFE00_0000); end
                else                  begin n = 5; code = 72'({8'hFF, hi}); end
            end
            else
            begin
                if (h >= -4)            begin n = 1; code = 72'(hi[7:0] & 8'hF7); end
                else if (h >= -512)     begin n = 2; code = 72'(hi[15:0] & 16'hFBFF); end
                else if (h >= -65536)   begin n = 3; code = 72'({8'hFD, hi[15:0]}); end
                else if (h >= -8388608) begin n = 4; code = 72'(hi & 32'hFEFF_FFFF); end
                else                    begin n = 5; code = 72'({8'hFF, hi}); end
            end
            code = (code << 32) | 72'(lo);
            n    = n + 4;
        end
        len_count[n]++;
        for (int i = n - 1; i >= 0; i--)
            expected_bytes.push_back('{data: code[i*8 +: 8], last: (i == 0)});
    endfunction

    task automatic send_value(input logic [63:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_encoding(v);
        values_sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Random magnitude width so that every encoding length shows up often.
    function automatic logic [63:0] random_value();
        logic [63:0] r;
        int          w;
        r = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            return r;
        w = $urandom_range(63);
        r = r & ((64'd1 << w) - 64'd1);
        if ($urandom_range(1) == 1)
            r = ~r;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin : check_output
            enc_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b (byte %02h)",
                                              m_tlast, want.last, want.data));
                bytes_checked++;
            end
        end
    end

    task automatic test_int_form();
        send_value(64'sd0);
        send_value(64'sd64);
        send_value(64'sd8191);
        send_value(64'sd1048576);
        send_value(64'sd134217727);
        send_value(64'sd134217728);
        send_value(64'sd2147483647);
        send_value(-64'sd1);
        send_value(-64'sd65);
        send_value(-64'sd8192);
        send_value(-64'sd1048577);
        send_value(-64'sd134217728);
        send_value(-64'sd134217729);
        send_value(-64'sd2147483648);
    endtask

    task automatic test_long_form();
        send_value(64'h0000_0000_8000_0000);
        send_value(64'h0000_01FF_0000_0001);
        send_value(64'h0000_FFFF_FFFF_FFFF);
        send_value(64'h007F_FFFF_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'hFFFF_FFFF_7FFF_FFFF);
        send_value(64'hFFFF_FFFB_1234_5678);
        send_value(64'hFFFF_0000_0000_0000);
        send_value(64'hFF80_0000_FFFF_FFFF);
        send_value(64'hFF7F_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'hA5A5_5A5A_C3C3_3C3C);
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_value(random_value());
    endtask

    // Fill the queue under backpressure, hold off until drained, then send again.
    task automatic test_pause_and_drain();
        idle_pct  = 0;
        stall_pct = 63;
        for (int i = 0; i < 10; i++)
            send_value(random_value());
        wait_all_results();
        for (int i = 0; i < 10; i++)
            send_value(random_value());
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        err_count = 0;
        values_sent   = 0;
        bytes_checked = 0;
        for (int i = 1; i <= MAX_BYTES; i++)
            len_count[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_int_form();
        test_long_form();
        test_random(50, 0, 0);
        test_random(45, 63, 0);
        test_random(45, 0, 63);
        test_pause_and_drain();
        test_random(45, 12, 12);

        s_tvalid <= 1'b0;
        for (int i = 0; i < 5000 && expected_bytes.size() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

        $display("Encoded %0d values into %0d checked bytes under mixed idle/stall traffic.",
                 values_sent, bytes_checked);
        $display("Lengths 1..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 len_count[1], len_count[2], len_count[3], len_count[4], len_count[5],
                 len_count[6], len_count[7], len_count[8], len_count[9]);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/cie_pkg.sv
hw/rtl/cie_front.sv
hw/rtl/cie_queue.sv
hw/rtl/cie_back.sv
hw/rtl/compact_integer_encoder_core.sv
tb/tb.sv
